// ===== hdl/bdq_pkg.sv =====
// Shared types and constants for the bounded deque block.
// No dependencies; compile first.
`default_nettype none

package bdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ACTION_W  = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_REMOVE     = 3'd4,
        ACT_LIST       = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_WALK,
        S_LIST,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_cmd;

endpackage

`default_nettype wire

// ===== hdl/bdq_intf.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on bdq_pkg.
`default_nettype none

interface bdq_req_if;
    import bdq_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface bdq_rsp_if;
    import bdq_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value_res;
    logic [STATUS_W-1:0]        status;
    logic [OCC_W-1:0]           occupancy;
    logic                       last;

    modport source (output valid, output value_res, output status, output occupancy,
                    output last, input ready);
    modport sink   (input valid, input value_res, input status, input occupancy,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/bdq_ram.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on bdq_pkg.
`default_nettype none

module bdq_ram #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  wire                          i_clk,
    input  wire bdq_pkg::t_mem_cmd       i_cmd,
    input  wire [AW-1:0]                 i_waddr,
    input  wire [bdq_pkg::VALUE_W-1:0]   i_wdata,
    input  wire [AW-1:0]                 i_raddr,
    output logic [bdq_pkg::VALUE_W-1:0]  o_rdata
);
    import bdq_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bdq_ctrl.sv =====
// Request sequencer: ring pointers, read-modify-write walks and result register.
// Depends on bdq_pkg, bdq_intf; drives bdq_ram.
`default_nettype none

module bdq_ctrl #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    bdq_req_if.sink                      i_req,
    bdq_rsp_if.source                    o_rsp,
    output bdq_pkg::t_mem_cmd            o_cmd,
    output logic [AW-1:0]                o_waddr,
    output logic [bdq_pkg::VALUE_W-1:0]  o_wdata,
    output logic [AW-1:0]                o_raddr,
    input  wire [bdq_pkg::VALUE_W-1:0]   i_rdata
);
    import bdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
        if (s >= (CW + 1)'(DEPTH)) begin
            s = s - (CW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    t_state             r_state, n_state;
    t_action            r_action;
    logic [VALUE_W-1:0] r_value;
    logic [AW-1:0]      r_front, n_front;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_rd_i, n_rd_i;
    logic [CW-1:0]      r_proc_i, n_proc_i;
    logic [CW-1:0]      r_kept, n_kept;
    logic               r_pend, n_pend;
    logic [VALUE_W-1:0] r_res_value, n_res_value;
    t_status            r_res_status, n_res_status;

    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    t_status            r_out_status;
    logic [OCC_W-1:0]   r_out_occ;
    logic               r_out_last;

    logic               can_emit;
    logic               emit;
    logic [VALUE_W-1:0] emit_value;
    t_status            emit_status;
    logic               emit_last;
    logic               accept;
    logic [AW-1:0]      front_dec;

    assign can_emit  = !r_out_valid || o_rsp.ready;
    assign accept    = i_req.valid && i_req.ready;
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.value_res = r_out_value;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.occupancy = r_out_occ;
    assign o_rsp.last      = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_rd_i       = r_rd_i;
        n_proc_i     = r_proc_i;
        n_kept       = r_kept;
        n_pend       = r_pend;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        o_cmd        = '0;
        o_waddr      = ring(r_front, r_kept);
        o_wdata      = i_rdata;
        o_raddr      = ring(r_front, r_rd_i);
        emit         = 1'b0;
        emit_value   = '0;
        emit_status  = ST_OK;
        emit_last    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state  = S_EXEC;
                    n_rd_i   = '0;
                    n_proc_i = '0;
                    n_kept   = '0;
                    n_pend   = 1'b0;
                end
            end
            S_EXEC: begin
                n_res_value  = '0;
                n_res_status = ST_OK;
                n_state      = S_EMIT;
                unique case (r_action)
                    ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            o_cmd.we = 1'b1;
                            o_wdata  = r_value;
                            n_count  = r_count + CW'(1);
                            if (r_action == ACT_PUSH_BACK) begin
                                o_waddr = ring(r_front, r_count);
                            end else begin
                                o_waddr = front_dec;
                                n_front = front_dec;
                            end
                        end
                    end
                    ACT_POP_BACK, ACT_POP_FRONT: begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            o_cmd.re = 1'b1;
                            n_count  = r_count - CW'(1);
                            n_state  = S_POP;
                            if (r_action == ACT_POP_BACK) begin
                                o_raddr = ring(r_front, r_count - CW'(1));
                            end else begin
                                o_raddr = r_front;
                                n_front = ring(r_front, CW'(1));
                            end
                        end
                    end
                    ACT_REMOVE: begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    ACT_LIST: begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            n_state = S_LIST;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POP: begin
                n_res_value = i_rdata;
                n_state     = S_EMIT;
            end
            S_WALK: begin
                n_pend = 1'b0;
                if (r_rd_i < r_count) begin
                    o_cmd.re = 1'b1;
                    n_rd_i   = r_rd_i + CW'(1);
                    n_pend   = 1'b1;
                end
                if (r_pend) begin
                    n_proc_i = r_proc_i + CW'(1);
                    if (i_rdata != r_value) begin
                        o_cmd.we = 1'b1;
                        n_kept   = r_kept + CW'(1);
                    end
                    if (r_proc_i == r_count - CW'(1)) begin
                        n_count      = n_kept;
                        n_res_value  = VALUE_W'(r_count - n_kept);
                        n_res_status = ST_OK;
                        n_state      = S_EMIT;
                    end
                end
            end
            S_LIST: begin
                if (r_pend && can_emit) begin
                    emit        = 1'b1;
                    emit_value  = i_rdata;
                    emit_last   = (r_proc_i == r_count - CW'(1));
                    n_proc_i    = r_proc_i + CW'(1);
                    n_pend      = 1'b0;
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end
                end
                if ((r_rd_i < r_count) && (!r_pend || can_emit)) begin
                    o_cmd.re = 1'b1;
                    n_rd_i   = r_rd_i + CW'(1);
                    n_pend   = 1'b1;
                end
            end
            S_EMIT: begin
                if (can_emit) begin
                    emit        = 1'b1;
                    emit_value  = r_res_value;
                    emit_status = r_res_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= t_action'(i_req.action);
            r_value  <= i_req.value;
        end
        r_rd_i       <= n_rd_i;
        r_proc_i     <= n_proc_i;
        r_kept       <= n_kept;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        if (emit) begin
            r_out_value  <= emit_value;
            r_out_status <= emit_status;
            r_out_occ    <= OCC_W'(r_count);
            r_out_last   <= emit_last;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bounded_deque_with_remove_value.sv =====
// Top level of the bounded deque with remove-by-value.
// Depends on bdq_pkg, bdq_intf, bdq_ram, bdq_ctrl.
//
// Requests are taken one at a time; the next one is taken once every result of the
// current one sits in the result register, so a result may wait on the output while
// the following request is accepted. A push or a failed or ignored request passes the
// execute and emit states, a pop the execute, read and emit states. Remove walks the
// held entries through the single read port of the entry memory, one entry a cycle
// with the write-back in the cycle after each read. A list gives one result a cycle
// while the output is drained.
// The entry memory needs no clearing after reset: only held entries are ever read.
`default_nettype none

module bounded_deque_with_remove_value #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bdq_req_if.sink     i_req,
    bdq_rsp_if.source   o_rsp
);
    import bdq_pkg::*;

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    t_mem_cmd           mem_cmd;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [VALUE_W-1:0] mem_rdata;

    bdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_cmd   (mem_cmd),
        .o_waddr (mem_waddr),
        .o_wdata (mem_wdata),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata)
    );

    bdq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== hdl/bdq_chk.sv =====
// Port-level checks for the bounded deque, bound to the top level.
// Depends on bdq_pkg and bounded_deque_with_remove_value.
`default_nettype none

module bdq_chk #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_rsp_valid,
    input wire                            i_rsp_ready,
    input wire [bdq_pkg::VALUE_W-1:0]     i_rsp_value,
    input wire [bdq_pkg::STATUS_W-1:0]    i_rsp_status,
    input wire [bdq_pkg::OCC_W-1:0]       i_rsp_occ,
    input wire                            i_rsp_last
);
    import bdq_pkg::*;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_occ <= OCC_W'(DEPTH)))
        else $error("occupancy beyond depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == ST_FULL) |->
            (i_rsp_occ == OCC_W'(DEPTH) && i_rsp_last && i_rsp_value == '0))
        else $error("full status on a store that is not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == ST_EMPTY) |->
            (i_rsp_occ == '0 && i_rsp_last && i_rsp_value == '0))
        else $error("empty status on a store that holds entries");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_status) &&
             $stable(i_rsp_occ) && $stable(i_rsp_last)))
        else $error("stalled transaction changed");

endmodule

bind bounded_deque_with_remove_value bdq_chk #(
    .DEPTH (DEPTH)
) u_bdq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_value  (o_rsp.value_res),
    .i_rsp_status (o_rsp.status),
    .i_rsp_occ    (o_rsp.occupancy),
    .i_rsp_last   (o_rsp.last)
);

`default_nettype wire

// ===== tb/sv/bounded_deque_with_remove_value_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bounded_deque_with_remove_value: directed and random requests,
// random idling on both channels, a long result hold-off, and a queue-based deque predictor.
// Depends on bdq_pkg, bdq_intf and the block's RTL.

module bounded_deque_with_remove_value_tb;
    import bdq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int N_RANDOM    = 150;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [VALUE_W-1:0] value_res;
        t_status                   status;
        logic [OCC_W-1:0]          occupancy;
        logic                      last;
    } deque_result_t;

    class deque_scoreboard;
        logic signed [VALUE_W-1:0] held[$];
        deque_result_t             due[$];
        int errors;
        int n_requests;
        int n_results;
        int n_full;
        int n_empty;
        int n_removed;
        int n_listed;

        function new();
            errors     = 0;
            n_requests = 0;
            n_results  = 0;
            n_full     = 0;
            n_empty    = 0;
            n_removed  = 0;
            n_listed   = 0;
        endfunction

        function void add_result(logic signed [VALUE_W-1:0] v, t_status st, logic lst);
            deque_result_t r;
            r.value_res = v;
            r.status    = st;
            r.occupancy = OCC_W'(held.size());
            r.last      = lst;
            if (st == ST_EMPTY) begin
                n_empty++;
            end
            due.push_back(r);
        endfunction

        function void note_request(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] v);
            logic signed [VALUE_W-1:0] kept[$];
            logic signed [VALUE_W-1:0] popped;
            int removed;
            n_requests++;
            case (act)
                ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                    if (held.size() >= DEPTH) begin
                        n_full++;
                        add_result(0, ST_FULL, 1'b1);
                    end else begin
                        if (act == ACT_PUSH_BACK) held.push_back(v);
                        else held.push_front(v);
                        add_result(0, ST_OK, 1'b1);
                    end
                end
                ACT_POP_BACK, ACT_POP_FRONT: begin
                    if (held.size() == 0) begin
                        add_result(0, ST_EMPTY, 1'b1);
                    end else begin
                        popped = (act == ACT_POP_BACK) ? held.pop_back() : held.pop_front();
                        add_result(popped, ST_OK, 1'b1);
                    end
                end
                ACT_REMOVE: begin
                    if (held.size() == 0) begin
                        add_result(0, ST_EMPTY, 1'b1);
                    end else begin
                        kept    = {};
                        removed = 0;
                        foreach (held[i]) begin
                            if (held[i] != v) kept.push_back(held[i]);
                            else removed++;
                        end
                        held = kept;
                        n_removed += removed;
                        add_result(removed, ST_OK, 1'b1);
                    end
                end
                ACT_LIST: begin
                    if (held.size() == 0) begin
                        add_result(0, ST_EMPTY, 1'b1);
                    end else begin
                        foreach (held[i]) begin
                            add_result(held[i], ST_OK, i == held.size() - 1);
                        end
                        n_listed += held.size();
                    end
                end
                default: begin
                    add_result(0, ST_OK, 1'b1);
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("%0t mismatch: %s", $time, msg);
            end
        endtask

        task check_result(logic signed [VALUE_W-1:0] v, logic [STATUS_W-1:0] st,
                          logic [OCC_W-1:0] occ, logic lst);
            deque_result_t r;
            n_results++;
            if (due.size() == 0) begin
                report($sformatf("unexpected result value %0d status %0d", v, st));
                return;
            end
            r = due.pop_front();
            if (v !== r.value_res)
                report($sformatf("value_res %0d, predicted %0d", v, r.value_res));
            if (st !== r.status)
                report($sformatf("status %0d, predicted %0d", st, r.status));
            if (occ !== r.occupancy)
                report($sformatf("occupancy %0d, predicted %0d", occ, r.occupancy));
            if (lst !== r.last)
                report($sformatf("last %0b, predicted %0b", lst, r.last));
        endtask

        function logic signed [VALUE_W-1:0] pick_held();
            if (held.size() == 0) return 0;
            return held[$urandom_range(0, held.size() - 1)];
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    bit              idling_on;
    bit              long_hold_req;
    deque_scoreboard board;

    bdq_req_if req_if();
    bdq_rsp_if rsp_if();

    bounded_deque_with_remove_value #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                board.check_result(rsp_if.value_res, rsp_if.status, rsp_if.occupancy,
                                   rsp_if.last);
            end
            if (req_if.valid && req_if.ready) begin
                board.note_request(req_if.action, req_if.value);
            end
        end
    end

    // hold off the result channel on request, else stall in random bursts
    always begin
        @(negedge clk);
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_if.ready  = 1'b0;
            repeat (LONG_HOLD) @(negedge clk);
        end
        if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge clk);
        end else begin
            rsp_if.ready = 1'b1;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 0;
            3:       return -1;
            4, 5:    return $urandom_range(1, 6);
            default: return $urandom;
        endcase
    endfunction

    task automatic issue(input logic [ACTION_W-1:0] act, input logic signed [VALUE_W-1:0] v);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.action = act;
        req_if.value  = v;
        req_if.valid  = 1'b1;
        do @(posedge clk); while (!req_if.ready);
    endtask

    initial begin
        logic [ACTION_W-1:0]       act;
        logic signed [VALUE_W-1:0] v;
        int                        roll;
        int                        push_upto;
        int                        pop_upto;

        board         = new();
        rst_n         = 1'b0;
        idling_on     = 1'b0;
        long_hold_req = 1'b0;
        req_if.valid  = 1'b0;
        req_if.action = ACT_PUSH_BACK;
        req_if.value  = '0;
        rsp_if.ready  = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queue and spare codes
        idling_on = 1'b1;
        issue(ACT_POP_BACK, VAL_MAX);
        issue(ACT_POP_FRONT, VAL_MIN);
        issue(ACT_REMOVE, 0);
        issue(ACT_LIST, -1);
        issue(ACT_SPARE_LO, VAL_MAX);
        issue(ACT_SPARE_HI, VAL_MIN);

        // extremes at both ends, duplicate removal, no-match removal
        issue(ACT_PUSH_BACK, VAL_MIN);
        issue(ACT_PUSH_FRONT, VAL_MAX);
        issue(ACT_PUSH_BACK, 0);
        issue(ACT_PUSH_FRONT, -1);
        issue(ACT_PUSH_BACK, VAL_MAX);
        issue(ACT_LIST, 0);
        issue(ACT_REMOVE, VAL_MAX);
        issue(ACT_REMOVE, 32'sh1234_5678);
        issue(ACT_POP_FRONT, 0);
        issue(ACT_POP_BACK, 0);
        issue(ACT_LIST, 0);
        issue(ACT_POP_BACK, 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            idling_on = (n < N_RANDOM - 30) && ((n / 25) % 3 != 2);
            if (n == 60) long_hold_req = 1'b1;
            push_upto = ((n / 20) % 2 == 0) ? 80 : 25;
            pop_upto  = ((n / 20) % 2 == 0) ? 85 : 80;
            roll      = $urandom_range(0, 99);
            v         = $urandom;
            if (roll < push_upto) begin
                act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                v   = pick_value();
            end else if (roll < pop_upto) begin
                act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
            end else if (roll < 91) begin
                act = ACT_REMOVE;
                v   = ($urandom_range(0, 2) != 0) ? board.pick_held() : pick_value();
            end else if (roll < 98) begin
                act = ACT_LIST;
            end else begin
                act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
            end
            issue(act, v);
        end

        @(negedge clk);
        req_if.valid = 1'b0;
        idling_on    = 1'b0;
        while (board.due.size() != 0) @(posedge clk);
        repeat (DEPTH + 12) @(posedge clk);

        $display("%0d requests, %0d results checked, %0d pushes refused when full",
                 board.n_requests, board.n_results, board.n_full);
        $display("%0d empty-queue results, %0d entries removed by value, %0d entries listed",
                 board.n_empty, board.n_removed, board.n_listed);
        if (board.errors == 0 && board.due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
